// ===== rtl/core/dilp_pkg.sv =====
`default_nettype none

package dilp_pkg;

	// One byte of text and its end-of-text flag
	typedef struct packed {
		logic [7:0] char_code;
		logic       is_last;
	} byte_word_t;

	// One parsed field value
	typedef struct packed {
		logic signed [31:0] value;
		logic               last_value;
	} result_word_t;

	typedef enum logic [5:0] {
		M_LEAD  = 6'b000001,
		M_DEC   = 6'b000010,
		M_ZERO  = 6'b000100,
		M_HEXWS = 6'b001000,
		M_HEX   = 6'b010000,
		M_DONE  = 6'b100000
	} mode_t;

	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_LOW_X  = 8'h78;
	localparam logic [7:0] CH_UP_X   = 8'h58;
	localparam logic [7:0] CH_LOW_H  = 8'h68;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LOW_A  = 8'h61;
	localparam logic [7:0] CH_LOW_F  = 8'h66;
	localparam logic [7:0] CASE_BIT  = 8'h20;

endpackage

`default_nettype wire

// ===== rtl/core/delimited_integer_list_parser_top.sv =====
// A byte word is taken into the input register and parsed from there; a result word it causes
// is written into the result queue and offered from the queue head; both words of a closing
// ';' are queued together, the second offered once the first is taken.
// Throughput: one byte word per cycle, set by the combinational parse and the four-entry
// result queue; the input stalls only while that queue holds three or more words.
// Reset (arst_n low, asynchronous) empties the input register and queue, restarts the field.
`default_nettype none

module delimited_integer_list_parser_top
	import dilp_pkg::*;
#(
	parameter int VALUE_BITS = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         byte_valid,
	output      logic         byte_stall,
	input  wire byte_word_t   byte_word,
	output      logic         result_valid,
	input  wire logic         result_stall,
	output      result_word_t result_word
);

	localparam int QDEPTH = 4;
	localparam int QPTR   = $clog2(QDEPTH);
	localparam int QCNT   = $clog2(QDEPTH + 1);

	typedef logic [VALUE_BITS-1:0] acc_t;

	// Input register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	// Field state
	mode_t mode_q;
	logic  neg_q;
	acc_t  dec_q;
	acc_t  hex_q;
	acc_t  held_q;

	// Result queue
	result_word_t          q_mem [QDEPTH];
	logic [QPTR-1:0]       rd_ptr_q;
	logic [QPTR-1:0]       wr_ptr_q;
	logic [QCNT-1:0]       count_q;

	logic                  adv;
	logic                  pop;
	logic [1:0]            push_n;
	result_word_t          res0;
	result_word_t          res1;

	mode_t mode_d;
	logic  neg_d;
	acc_t  dec_d;
	acc_t  hex_d;
	acc_t  held_d;

	logic       is_dig;
	logic       is_hl;
	logic       is_ws;
	logic [7:0] lc;
	logic [3:0] dig;
	logic [3:0] hl_val;
	logic [3:0] hd;
	logic       dec_path;
	acc_t       dec_mul;
	acc_t       sdec;

	function automatic logic [31:0] field_val(mode_t m, logic ng, acc_t d, acc_t h,
			acc_t hd_v);
		acc_t        v;
		logic [63:0] ext;
		if (m == M_HEXWS || m == M_HEX) begin
			v = h;
		end else if (m == M_DONE) begin
			v = hd_v;
		end else begin
			v = ng ? (acc_t'(0) - d) : d;
		end
		ext = 64'(v);
		return ext[31:0];
	endfunction

	assign adv          = valid_s1 && (count_q <= QCNT'(QDEPTH - 2));
	assign byte_stall   = valid_s1 && !adv;
	assign result_valid = (count_q != '0);
	assign result_word  = q_mem[rd_ptr_q];
	assign pop          = result_valid && !result_stall;

	// Character classes
	assign lc     = char_s1 | CASE_BIT;
	assign is_dig = (char_s1 >= CH_ZERO) && (char_s1 <= CH_NINE);
	assign is_hl  = (lc >= CH_LOW_A) && (lc <= CH_LOW_F);
	assign is_ws  = (char_s1 == CH_SPACE) || ((char_s1 >= CH_TAB) && (char_s1 <= CH_CR));
	assign dig    = char_s1[3:0];
	assign hl_val = lc[3:0] + 4'd9;
	assign hd     = is_dig ? dig : hl_val;

	assign dec_mul = (dec_q << 3) + (dec_q << 1) + acc_t'(dig);
	assign sdec    = neg_q ? (acc_t'(0) - dec_q) : dec_q;

	always_comb begin
		mode_d   = mode_q;
		neg_d    = neg_q;
		dec_d    = dec_q;
		hex_d    = hex_q;
		held_d   = held_q;
		dec_path = 1'b0;
		push_n   = 2'd0;
		res0     = '0;
		res1     = '0;

		if (char_s1 != CH_SEMI) begin
			unique case (mode_q)
				M_LEAD: begin
					if (is_ws) begin
						mode_d = M_LEAD;
					end else if (char_s1 == CH_PLUS) begin
						mode_d = M_DEC;
					end else if (char_s1 == CH_MINUS) begin
						neg_d  = 1'b1;
						mode_d = M_DEC;
					end else if (char_s1 == CH_LOW_X || char_s1 == CH_LOW_H ||
							char_s1 == CH_HASH || char_s1 == CH_DOLLAR) begin
						mode_d = M_HEXWS;
					end else if (char_s1 == CH_ZERO) begin
						mode_d = M_ZERO;
					end else begin
						dec_path = 1'b1;
					end
				end
				M_ZERO: begin
					if (char_s1 == CH_LOW_X || char_s1 == CH_UP_X) begin
						mode_d = M_HEXWS;
					end else begin
						dec_path = 1'b1;
					end
				end
				M_DEC: begin
					dec_path = 1'b1;
				end
				M_HEXWS, M_HEX: begin
					if (mode_q == M_HEXWS && is_ws) begin
						mode_d = M_HEXWS;
					end else if (is_dig || is_hl) begin
						hex_d  = {hex_q[VALUE_BITS-5:0], hd};
						mode_d = M_HEX;
					end else begin
						held_d = hex_q;
						mode_d = M_DONE;
					end
				end
				M_DONE: begin
					mode_d = M_DONE;
				end
				default: begin
					mode_d = M_DONE;
				end
			endcase

			if (dec_path) begin
				priority if (is_dig) begin
					dec_d  = dec_mul;
					hex_d  = {hex_q[VALUE_BITS-5:0], dig};
					mode_d = M_DEC;
				end else if (is_hl) begin
					// hex letter in a decimal field: reread the field as unsigned hex
					hex_d  = {hex_q[VALUE_BITS-5:0], hl_val};
					mode_d = M_HEX;
				end else if (char_s1 == CH_LOW_X || char_s1 == CH_LOW_H) begin
					held_d = hex_q;
					mode_d = M_DONE;
				end else begin
					held_d = sdec;
					mode_d = M_DONE;
				end
			end

			if (last_s1) begin
				res0.value      = field_val(mode_d, neg_d, dec_d, hex_d, held_d);
				res0.last_value = 1'b1;
				push_n          = 2'd1;
			end
		end else begin
			res0.value      = field_val(mode_q, neg_q, dec_q, hex_q, held_q);
			res0.last_value = 1'b0;
			push_n          = 2'd1;
			if (last_s1) begin
				// empty trailing field after a closing ';'
				res1.value      = '0;
				res1.last_value = 1'b1;
				push_n          = 2'd2;
			end
		end

		// a separator or the end of text starts a new field
		if (char_s1 == CH_SEMI || last_s1) begin
			mode_d = M_LEAD;
			neg_d  = 1'b0;
			dec_d  = '0;
			hex_d  = '0;
			held_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			char_s1 <= byte_word.char_code;
			last_s1 <= byte_word.is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_LEAD;
			neg_q  <= 1'b0;
			dec_q  <= '0;
			hex_q  <= '0;
			held_q <= '0;
		end else if (adv) begin
			mode_q <= mode_d;
			neg_q  <= neg_d;
			dec_q  <= dec_d;
			hex_q  <= hex_d;
			held_q <= held_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && push_n != 2'd0) begin
			q_mem[wr_ptr_q] <= res0;
		end
		if (adv && push_n == 2'd2) begin
			q_mem[wr_ptr_q + QPTR'(1)] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (adv) begin
				wr_ptr_q <= wr_ptr_q + QPTR'(push_n);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR'(1);
			end
			count_q <= count_q + (adv ? QCNT'(push_n) : QCNT'(0)) - QCNT'(pop);
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT'(QDEPTH))
		else $error("result queue overfilled");

	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> valid_s1)
		else $error("byte stall with empty input register");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> mode_q == M_LEAD && dec_q == '0 && hex_q == '0)
		else $error("field state not cleared after end of text");

	a_semi_last_two: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 && char_s1 == CH_SEMI |=> count_q >= QCNT'(1) &&
		count_q == $past(count_q) + QCNT'(2) - QCNT'($past(pop)))
		else $error("closing separator did not queue two words");
`endif

endmodule

`default_nettype wire
